// File: src/u8d_pkg.sv
// shared types, constants and helpers of the utf-8 code point decoder
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned ADV_W = 3;

    localparam logic [CP_W-1:0] ERR_CODE_POINT = 21'h00FFFF;
    localparam logic [CP_W-1:0] MIN_THREE      = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR       = 21'h010000;
    localparam logic [CP_W-1:0] CP_LIMIT       = 21'h110000;
    localparam logic [CP_W-1:0] NONCHAR_LO     = 21'h00FDD0;
    localparam logic [CP_W-1:0] NONCHAR_HI     = 21'h00FDEF;
    localparam logic [9:0]      SURR_HIGH_BITS = 10'h01B;  // 0xd800 >> 11
    localparam logic [CP_W-1:0] ASCII_LIMIT    = 21'h000080;

    localparam logic [ADV_W-1:0] ADV_ONE   = 3'd1;
    localparam logic [ADV_W-1:0] ADV_TWO   = 3'd2;
    localparam logic [ADV_W-1:0] ADV_THREE = 3'd3;
    localparam logic [ADV_W-1:0] ADV_FOUR  = 3'd4;

    typedef enum logic [2:0] {
        FORM_ASCII,
        FORM_TWO,
        FORM_THREE,
        FORM_FOUR,
        FORM_BAD
    } t_form;

    // after lead decode and continuation checks
    typedef struct packed {
        t_form            form;
        logic             seq_ok;
        logic [CP_W-1:0]  value;
    } t_cls;

    // after range and validity checks
    typedef struct packed {
        t_form            form;
        logic             bad;
        logic [CP_W-1:0]  value;
    } t_chk;

    function automatic logic [ADV_W-1:0] form_len(input t_form form);
        logic [ADV_W-1:0] len;
        unique case (form)
            FORM_ASCII: len = ADV_ONE;
            FORM_TWO:   len = ADV_TWO;
            FORM_THREE: len = ADV_THREE;
            FORM_FOUR:  len = ADV_FOUR;
            default:    len = ADV_ONE;
        endcase
        return len;
    endfunction

endpackage

// File: src/u8d_classify.sv
// stage one: lead byte decode, continuation checks and value assembly
`timescale 1ns / 1ps

module u8d_classify
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cls        o_cls
);

    logic  r_valid;
    t_cls  r_cls;
    t_cls  n_cls;
    logic  c1_ok;
    logic  c2_ok;
    logic  c3_ok;

    assign c1_ok = (i_byte1[7:6] == 2'b10);
    assign c2_ok = (i_byte2[7:6] == 2'b10);
    assign c3_ok = (i_byte3[7:6] == 2'b10);

    always_comb begin
        n_cls.form   = FORM_BAD;
        n_cls.seq_ok = 1'b0;
        n_cls.value  = ERR_CODE_POINT;
        unique casez (i_byte0)
            8'b0???????: begin
                n_cls.form   = FORM_ASCII;
                n_cls.seq_ok = 1'b1;
                n_cls.value  = {14'd0, i_byte0[6:0]};
            end
            8'b110?????: begin
                // c0 and c1 are overlong leads
                n_cls.form   = FORM_TWO;
                n_cls.seq_ok = (i_byte0[4:1] != 4'd0) && c1_ok;
                n_cls.value  = {10'd0, i_byte0[4:0], i_byte1[5:0]};
            end
            8'b1110????: begin
                n_cls.form   = FORM_THREE;
                n_cls.seq_ok = c1_ok && c2_ok;
                n_cls.value  = {5'd0, i_byte0[3:0], i_byte1[5:0], i_byte2[5:0]};
            end
            8'b11110???: begin
                n_cls.form   = FORM_FOUR;
                n_cls.seq_ok = c1_ok && c2_ok && c3_ok;
                n_cls.value  = {i_byte0[2:0], i_byte1[5:0], i_byte2[5:0], i_byte3[5:0]};
            end
            default: begin
                // stray continuation byte or f8-ff lead
                n_cls.form   = FORM_BAD;
                n_cls.seq_ok = 1'b0;
                n_cls.value  = ERR_CODE_POINT;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

// File: src/u8d_check.sv
// stage two: minimum value and code point validity checks
`timescale 1ns / 1ps

module u8d_check
    import u8d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cls  i_cls,
    output logic  o_valid,
    input  logic  i_ready,
    output t_chk  o_chk
);

    logic  r_valid;
    t_chk  r_chk;
    t_chk  n_chk;
    logic  below_min;
    logic  cp_ok;
    logic  long_form;

    assign long_form = (i_cls.form == FORM_THREE) || (i_cls.form == FORM_FOUR);
    assign below_min = (i_cls.form == FORM_THREE) ? (i_cls.value < MIN_THREE)
                                                  : (i_cls.value < MIN_FOUR);

    // reject out of range, surrogates, fdd0-fdef and xfffe/xffff
    assign cp_ok = (i_cls.value < CP_LIMIT)
                && (i_cls.value[20:11] != SURR_HIGH_BITS)
                && !((i_cls.value >= NONCHAR_LO) && (i_cls.value <= NONCHAR_HI))
                && (i_cls.value[15:1] != 15'h7FFF);

    always_comb begin
        n_chk.form  = i_cls.form;
        n_chk.value = i_cls.value;
        n_chk.bad   = !i_cls.seq_ok || (i_cls.form == FORM_BAD)
                   || (long_form && (below_min || !cp_ok));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_chk <= n_chk;
        end
    end

    assign o_valid = r_valid;
    assign o_chk   = r_chk;

endmodule

// File: src/u8d_emit.sv
// stage three: result selection and output register
`timescale 1ns / 1ps

module u8d_emit
    import u8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_chk              i_chk,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CP_W-1:0]   o_code_point,
    output logic [ADV_W-1:0]  o_advance,
    output logic              o_invalid
);

    logic              r_valid;
    logic [CP_W-1:0]   r_code_point;
    logic [ADV_W-1:0]  r_advance;
    logic              r_invalid;
    logic [CP_W-1:0]   n_code_point;
    logic [ADV_W-1:0]  n_advance;

    // on error resync one byte past the lead
    assign n_code_point = i_chk.bad ? ERR_CODE_POINT : i_chk.value;
    assign n_advance    = i_chk.bad ? ADV_ONE : form_len(i_chk.form);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code_point <= n_code_point;
            r_advance    <= n_advance;
            r_invalid    <= i_chk.bad;
        end
    end

    assign o_valid      = r_valid;
    assign o_code_point = r_code_point;
    assign o_advance    = r_advance;
    assign o_invalid    = r_invalid;

endmodule

// File: src/utf8_code_point_decoder.sv
// top level of the utf-8 code point decoder: three register stages
`timescale 1ns / 1ps
//
//  channel   direction  handshake                       payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata[31:0] byte0..byte3
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata[23:0] code_point,advance
//                                                        tuser[0]    invalid
//
//  one character per cycle sustained while the output is not stalled; one register
//  per stage (classify, check, emit), so each character passes the classify, check
//  and emit registers in that order before its result can be transferred
//  ready travels back combinationally: a stage loads when empty or draining,
//  so a stall on the output holds every stage and nothing is dropped
//  i_rst_n is synchronous, active low, and clears only the stage valid bits

module utf8_code_point_decoder
    import u8d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [23:0]  o_m_axis_tdata,   // code_point[20:0], advance[23:21]
    output logic [0:0]   o_m_axis_tuser    // invalid[0]
);

    // stage handshakes
    logic              cls_valid;
    logic              cls_ready;
    t_cls              cls_data;
    logic              chk_valid;
    logic              chk_ready;
    t_chk              chk_data;

    // output fields
    logic [CP_W-1:0]   code_point;
    logic [ADV_W-1:0]  advance;
    logic              invalid;

    // lead decode, continuation bytes, raw value
    u8d_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte0 (i_s_axis_tdata[7:0]),
        .i_byte1 (i_s_axis_tdata[15:8]),
        .i_byte2 (i_s_axis_tdata[23:16]),
        .i_byte3 (i_s_axis_tdata[31:24]),
        .o_valid (cls_valid),
        .i_ready (cls_ready),
        .o_cls   (cls_data)
    );

    // overlong and code point validity tests
    u8d_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_cls   (cls_data),
        .o_valid (chk_valid),
        .i_ready (chk_ready),
        .o_chk   (chk_data)
    );

    // error substitution and output register
    u8d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (chk_valid),
        .o_ready      (chk_ready),
        .i_chk        (chk_data),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_code_point (code_point),
        .o_advance    (advance),
        .o_invalid    (invalid)
    );

    assign o_m_axis_tdata = {advance, code_point};
    assign o_m_axis_tuser = invalid;

    // a rejected sequence always reports the error value with a single byte advance
    a_err_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && invalid) |-> (code_point == ERR_CODE_POINT) && (advance == ADV_ONE))
        else $error("invalid result without error code point or unit advance");

    // advance of an accepted sequence is its length, never zero or above four
    a_adv_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (advance != 3'd0) && (advance <= ADV_FOUR))
        else $error("advance out of range");

    // a good single byte result is plain ascii
    a_ascii : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !invalid && (advance == ADV_ONE)) |-> (code_point < ASCII_LIMIT))
        else $error("single byte result outside ascii");

    // a good result is always below the code space limit
    a_cp_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !invalid) |-> (code_point < CP_LIMIT))
        else $error("valid code point above code space");

endmodule

// File: tb/utf8_code_point_decoder_test.sv
// self-checking testbench of the utf-8 code point decoder stream block
`timescale 1ns / 1ps

module utf8_code_point_decoder_test;
    import u8d_pkg::*;

    // one decoded character as it leaves the block
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [ADV_W-1:0] advance;
        logic             invalid;
    } t_char_result;

    // byte windows read right to left: byte0 in the low byte
    localparam int N_CORNER = 26;
    localparam logic [31:0] CORNER_WINDOWS [N_CORNER] = '{
        32'h00000000,  // nul
        32'hFFFFFF7F,  // highest single byte, junk after it
        32'h000080C0,  // overlong lead c0
        32'h0000BFC1,  // overlong lead c1
        32'h000080C2,  // lowest two-byte
        32'h0000BFDF,  // highest two-byte
        32'h000041C2,  // two-byte with bad continuation
        32'h0080A0E0,  // lowest three-byte
        32'h00BF9FE0,  // overlong three-byte
        32'h00BF9FED,  // just below the surrogates
        32'h0080A0ED,  // first surrogate
        32'h0090B7EF,  // fdd0
        32'h00AFB7EF,  // fdef
        32'h00B0B7EF,  // fdf0, allowed
        32'h00BEBFEF,  // fffe
        32'h00BFBFEF,  // ffff
        32'h00C080E1,  // three-byte with bad third byte
        32'h808090F0,  // lowest four-byte
        32'hBFBF8FF0,  // overlong four-byte
        32'hBDBF8FF4,  // 10fffd
        32'hBFBF8FF4,  // 10ffff, low half ffff
        32'h808090F4,  // past the last plane
        32'h7F8080F1,  // four-byte with bad fourth byte
        32'h80808080,  // continuation as lead
        32'h808080F8,  // f8 lead
        32'hFFFFFFFF   // ff lead
    };

    // code points around the boundaries of the validity test
    localparam int N_EDGE_PTS = 20;
    localparam logic [CP_W-1:0] EDGE_POINTS [N_EDGE_PTS] = '{
        21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
        21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FDCF, 21'h00FDD0,
        21'h00FDEF, 21'h00FDF0, 21'h00FFFD, 21'h00FFFE, 21'h00FFFF,
        21'h010000, 21'h01FFFF, 21'h10FFFD, 21'h10FFFF, 21'h110000
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic [0:0]  m_user;

    t_char_result pending_chars[$];
    t_char_result want_char;
    int fail_count     = 0;
    int window_count   = 0;
    int rejected_count = 0;
    int multibyte_count = 0;

    // pacing of both sides
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_go  = 1'b0;
    int rx_hold_len = 0;
    int rx_hold_left = 0;
    int rx_gap      = 0;

    utf8_code_point_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic bit scalar_ok(input logic [CP_W-1:0] v);
        return (v < CP_LIMIT) && (v[20:11] != SURR_HIGH_BITS) &&
               !(v >= NONCHAR_LO && v <= NONCHAR_HI) && (v[15:1] != 15'h7FFF);
    endfunction

    function automatic t_char_result decode_utf8(input logic [31:0] window);
        logic [7:0]      b0, b1, b2, b3;
        logic [CP_W-1:0] v;
        bit              ok;
        t_char_result    r;
        b0 = window[7:0];
        b1 = window[15:8];
        b2 = window[23:16];
        b3 = window[31:24];
        ok = 1'b0;
        v = '0;
        r.advance = ADV_ONE;
        if (b0[7] == 1'b0) begin
            v = {14'b0, b0[6:0]};
            ok = 1'b1;
        end else if (b0[7:5] == 3'b110) begin
            // c0 and c1 would only give overlong forms
            if (b0[4:1] != 4'b0 && b1[7:6] == 2'b10) begin
                v = {10'b0, b0[4:0], b1[5:0]};
                ok = 1'b1;
                r.advance = ADV_TWO;
            end
        end else if (b0[7:4] == 4'b1110) begin
            if (b1[7:6] == 2'b10 && b2[7:6] == 2'b10) begin
                v = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
                ok = (v >= MIN_THREE) && scalar_ok(v);
                r.advance = ADV_THREE;
            end
        end else if (b0[7:3] == 5'b11110) begin
            if (b1[7:6] == 2'b10 && b2[7:6] == 2'b10 && b3[7:6] == 2'b10) begin
                v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                ok = (v >= MIN_FOUR) && scalar_ok(v);
                r.advance = ADV_FOUR;
            end
        end
        if (!ok) begin
            v = ERR_CODE_POINT;
            r.advance = ADV_ONE;
        end
        r.code_point = v;
        r.invalid = !ok;
        return r;
    endfunction

    // encodes a random character, sometimes overlong, out of range or with a broken byte
    function automatic logic [31:0] random_window(input int bad_pct);
        logic [31:0]     word;
        logic [CP_W-1:0] cp;
        int              len;
        int              natural_len;
        int              k;
        int              pick;
        word = $urandom;
        pick = $urandom_range(0, 9);
        case (pick) inside
            0, 1:    cp = CP_W'($urandom_range(0, 'h7F));
            2:       cp = CP_W'($urandom_range('h80, 'h7FF));
            3, 4:    cp = CP_W'($urandom_range('h800, 'hFFFF));
            5, 6:    cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            7:       cp = EDGE_POINTS[$urandom_range(0, N_EDGE_PTS - 1)];
            8:       cp = CP_W'($urandom_range(0, 'hFFFF));
            default: cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
        endcase
        natural_len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        len = natural_len;
        if (pick == 8 && natural_len < 4) begin
            len = $urandom_range(natural_len + 1, 4);
        end
        case (len)
            1: word[7:0] = {1'b0, cp[6:0]};
            2: begin
                word[7:0]  = {3'b110, cp[10:6]};
                word[15:8] = {2'b10, cp[5:0]};
            end
            3: begin
                word[7:0]   = {4'b1110, cp[15:12]};
                word[15:8]  = {2'b10, cp[11:6]};
                word[23:16] = {2'b10, cp[5:0]};
            end
            default: begin
                word[7:0]   = {5'b11110, cp[20:18]};
                word[15:8]  = {2'b10, cp[17:12]};
                word[23:16] = {2'b10, cp[11:6]};
                word[31:24] = {2'b10, cp[5:0]};
            end
        endcase
        // break one continuation byte
        if (len > 1 && $urandom_range(0, 99) < bad_pct) begin
            k = $urandom_range(1, len - 1);
            case ($urandom_range(0, 2))
                0:       word[8*k+6 +: 2] = 2'b00;
                1:       word[8*k+6 +: 2] = 2'b01;
                default: word[8*k+6 +: 2] = 2'b11;
            endcase
        end
        return word;
    endfunction

    // offers one window and returns once it is transferred; valid stays high
    task automatic send_window(input logic [31:0] window);
        int gap;
        t_char_result r;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= window;
        do @(posedge i_clk); while (!s_ready);
        r = decode_utf8(window);
        pending_chars.push_back(r);
        window_count++;
        if (r.invalid) rejected_count++;
        if (r.advance > ADV_ONE) multibyte_count++;
    endtask

    // drop valid and wait until every expected character has come out
    task automatic finish_phase();
        s_valid <= 1'b0;
        for (int n = 0; n < 5000 && pending_chars.size() > 0; n++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // only called with valid low
    task automatic set_pace(input bit tx, input bit rx);
        @(negedge i_clk);
        tx_steady = tx;
        rx_steady = rx;
        @(posedge i_clk);
    endtask

    task automatic test_corner_windows();
        for (int i = 0; i < N_CORNER; i++) send_window(CORNER_WINDOWS[i]);
        finish_phase();
    endtask

    task automatic test_encoded_text();
        for (int i = 0; i < 600; i++) send_window(random_window(12));
        finish_phase();
        // back to back on both sides
        set_pace(1'b1, 1'b1);
        for (int i = 0; i < 300; i++) send_window(random_window(12));
        finish_phase();
        set_pace(1'b0, 1'b0);
    endtask

    task automatic test_random_bytes();
        logic [31:0] word;
        for (int i = 0; i < 350; i++) begin
            word = $urandom;
            // half of the time make the trailing bytes look like continuations
            if ($urandom_range(0, 1) == 1) begin
                word[15:14] = 2'b10;
                word[23:22] = 2'b10;
                word[31:30] = 2'b10;
            end
            send_window(word);
        end
        finish_phase();
    endtask

    task automatic test_backpressure();
        set_pace(1'b1, 1'b0);
        @(negedge i_clk);
        rx_hold_len = 60;
        rx_hold_go  = 1'b1;
        @(posedge i_clk);
        // the pipeline fills during the hold and stalls the sender
        for (int i = 0; i < 40; i++) send_window(random_window(20));
        finish_phase();
        set_pace(1'b0, 1'b1);
        for (int i = 0; i < 60; i++) send_window(random_window(20));
        finish_phase();
        set_pace(1'b0, 1'b0);
    endtask

    // receiver: checks each result transfer, then draws its next stall
    always @(posedge i_clk) begin
        if (m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tuser %b",
                       m_data, m_user);
                fail_count++;
            end else begin
                want_char = pending_chars.pop_front();
                if (m_data[20:0] !== want_char.code_point) begin
                    $error("code_point: expected %h, got %h",
                           want_char.code_point, m_data[20:0]);
                    fail_count++;
                end
                if (m_data[23:21] !== want_char.advance) begin
                    $error("advance: expected %0d, got %0d",
                           want_char.advance, m_data[23:21]);
                    fail_count++;
                end
                if (m_user[0] !== want_char.invalid) begin
                    $error("invalid: expected %b, got %b", want_char.invalid, m_user[0]);
                    fail_count++;
                end
            end
            rx_gap = rx_steady ? 0 : $urandom_range(0, 3);
        end
        if (rx_hold_go) begin
            rx_hold_left = rx_hold_len;
            rx_hold_go = 1'b0;
        end
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_windows();
        test_encoded_text();
        test_random_bytes();
        test_backpressure();

        if (pending_chars.size() != 0) begin
            $error("%0d expected characters never came out", pending_chars.size());
            fail_count++;
        end
        $display("decoded %0d windows: %0d multibyte characters, %0d rejected",
                 window_count, multibyte_count, rejected_count);
        $display("covered corner windows, encoded text, raw bytes and a long output stall");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
